@@ rtl/hpq_pkg.sv @@
// Shared constants, types and helpers for the max-heap priority queue.
package hpq_pkg;

    localparam int CAPACITY = 128;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = ADDR_W + 2;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [POS_W-1:0]        pos_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [1:0]              status_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // signed compare a < b
    function automatic logic key_less(input key_t a, input key_t b);
        return a < b;
    endfunction

    // 1-based heap position to store address
    function automatic addr_t addr_of(input pos_t pos);
        pos_t t;
        t = pos - POS_W'(1);
        return t[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/hpq_ram.sv @@
// Heap key store: one write port, two read ports with registered read data.
module hpq_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ rtl/max_heap_priority_queue.sv @@
// Max-heap priority queue top level: request sequencer around the key store.
//
//  channel   | handshake          | fields
//  ----------+--------------------+-------------------------------
//  request   | start / busy       | req_type, key_in
//  result    | done (1-cycle)     | key_out, status, count
//
// A request is taken when start is high and busy is low. The sift walks one
// heap level per cycle: the store's read for the next level is issued in the
// same cycle as the write-back of the current one, so a request keeps busy
// high while it walks the heap levels, for insert and pop alike; refused
// requests and an insert into an empty heap finish
// without raising busy. done pulses in the cycle after busy drops, and a new
// request may be taken in that same cycle.
// Reset clears the count, the sequencer and done only; the store needs no clearing
// since entries at or past the count are never used. The receiver cannot
// stall, so nothing holds results back.
module max_heap_priority_queue
    import hpq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  logic    req_type,
    input  key_t    key_in,
    output logic    done,
    output key_t    key_out,
    output status_t status,
    output cnt_t    count
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for a request
    localparam logic [2:0] S_UP   = 3'd1;   // insert: parent key in read data
    localparam logic [2:0] S_POP0 = 3'd2;   // pop: root and last in read data
    localparam logic [2:0] S_DOWN = 3'd3;   // pop: both children in read data
    localparam logic [2:0] S_FIN  = 3'd4;   // drop the held key into the hole

    logic [2:0] state_reg, state_next;
    cnt_t       count_reg, count_next;
    pos_t       pos_reg,   pos_next;     // current hole (1-based)
    pos_t       kid_reg,   kid_next;     // left child under the hole
    key_t       key_reg,   key_next;     // key being sifted
    key_t       top_reg,   top_next;     // popped root
    logic       req_reg,   req_next;

    logic       done_reg,    done_next;
    key_t       key_out_reg, key_out_next;
    status_t    status_reg,  status_next;

    // store ports
    logic  we;
    addr_t waddr;
    key_t  wdata;
    addr_t raddr_a;
    addr_t raddr_b;
    key_t  rdata_a;
    key_t  rdata_b;

    // datapath helpers
    pos_t  n_pos;
    pos_t  par_pos;
    logic  take_right;
    key_t  child_key;
    pos_t  kid_sel;
    pos_t  kid2;

    hpq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_W)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign n_pos      = POS_W'(count_reg);
    assign par_pos    = pos_reg >> 1;
    // right child exists only when kid < n; ties go left
    assign take_right = (kid_reg < n_pos) && key_less(rdata_a, rdata_b);
    assign child_key  = take_right ? rdata_b : rdata_a;
    assign kid_sel    = kid_reg + POS_W'(take_right);
    assign kid2       = kid_sel << 1;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        kid_next     = kid_reg;
        key_next     = key_reg;
        top_next     = top_reg;
        req_next     = req_reg;
        done_next    = 1'b0;
        key_out_next = key_out_reg;
        status_next  = status_reg;
        we           = 1'b0;
        waddr        = addr_of(pos_reg);
        wdata        = key_reg;
        raddr_a      = '0;
        raddr_b      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req_type;
                    key_next = key_in;
                    if (req_type == REQ_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            done_next    = 1'b1;
                            status_next  = ST_FULL;
                            key_out_next = '0;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                            pos_next   = n_pos + POS_W'(1);
                            if (count_reg == '0)
                            begin
                                // empty heap: key becomes the root at once
                                we           = 1'b1;
                                waddr        = '0;
                                wdata        = key_in;
                                done_next    = 1'b1;
                                status_next  = ST_OK;
                                key_out_next = '0;
                            end
                            else
                            begin
                                raddr_a    = addr_of((n_pos + POS_W'(1)) >> 1);
                                state_next = S_UP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            done_next    = 1'b1;
                            status_next  = ST_EMPTY;
                            key_out_next = '0;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                            raddr_a    = '0;
                            raddr_b    = addr_of(n_pos);
                            pos_next   = POS_W'(1);
                            state_next = S_POP0;
                        end
                    end
                end
            end

            S_UP:
            begin
                if (key_less(rdata_a, key_reg))
                begin
                    // parent moves down into the hole
                    we       = 1'b1;
                    waddr    = addr_of(pos_reg);
                    wdata    = rdata_a;
                    pos_next = par_pos;
                    if (par_pos == POS_W'(1))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        raddr_a = addr_of(par_pos >> 1);
                    end
                end
                else
                begin
                    we           = 1'b1;
                    done_next    = 1'b1;
                    status_next  = ST_OK;
                    key_out_next = '0;
                    state_next   = S_IDLE;
                end
            end

            S_POP0:
            begin
                top_next = rdata_a;
                key_next = rdata_b;
                kid_next = POS_W'(2);
                if (n_pos >= POS_W'(2))
                begin
                    raddr_a    = addr_of(POS_W'(2));
                    raddr_b    = addr_of(POS_W'(3));
                    state_next = S_DOWN;
                end
                else
                begin
                    // at most one key left: it becomes the root
                    we           = 1'b1;
                    waddr        = '0;
                    wdata        = rdata_b;
                    done_next    = 1'b1;
                    status_next  = ST_OK;
                    key_out_next = rdata_a;
                    state_next   = S_IDLE;
                end
            end

            S_DOWN:
            begin
                we = 1'b1;
                if (!key_less(key_reg, child_key))
                begin
                    done_next    = 1'b1;
                    status_next  = ST_OK;
                    key_out_next = top_reg;
                    state_next   = S_IDLE;
                end
                else
                begin
                    // larger child moves up into the hole
                    wdata    = child_key;
                    pos_next = kid_sel;
                    kid_next = kid2;
                    if (kid2 <= n_pos)
                    begin
                        raddr_a = addr_of(kid2);
                        raddr_b = addr_of(kid2 + POS_W'(1));
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                we           = 1'b1;
                done_next    = 1'b1;
                status_next  = ST_OK;
                key_out_next = (req_reg == REQ_POP) ? top_reg : '0;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        kid_reg     <= kid_next;
        key_reg     <= key_next;
        top_reg     <= top_next;
        req_reg     <= req_next;
        key_out_reg <= key_out_next;
        status_reg  <= status_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign key_out = key_out_reg;
    assign status  = status_reg;
    assign count   = count_reg;

endmodule

@@ rtl/hpq_check.sv @@
// Port-level checker for the max-heap priority queue, bound to the top level.
module hpq_check
    import hpq_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input key_t    key_out,
    input status_t status,
    input cnt_t    count
);

    // every taken request is either still in work or answered next cycle
    a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request neither in work nor answered");

    // a result never overlaps the sift of a request
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // refused insert only when full, refused pop only when empty
    a_refuse_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == ST_OK)
                  || (status == ST_FULL && count == CNT_W'(CAPACITY))
                  || (status == ST_EMPTY && count == '0)))
        else $error("refusal status does not match count");

    // refused requests return a zero key
    a_refuse_key: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (key_out == '0))
        else $error("refused request returned a key");

    // count moves only when a request is taken
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> $stable(count))
        else $error("count changed without a request");

endmodule

bind max_heap_priority_queue hpq_check u_hpq_check (.*);
